[rtl/kqt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_pkg: shared definitions for the keyed quantity table
// operation and status codes, field widths, table write controls
// ----------------------------------------------------------------------------
package kqt_pkg;

  localparam int KQT_ENTRIES = 16;
  localparam int FUNC_W      = 2;
  localparam int KEY_W       = 16;
  localparam int QTY_W       = 16;
  localparam int AMT_W       = 32;
  localparam int STATUS_W    = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD   = 2'd0,
    FN_TAKE  = 2'd1,
    FN_QUERY = 2'd2,
    FN_SPARE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 3'd0,
    ST_ADDED     = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_SHORT     = 3'd3,
    ST_MISSING   = 3'd4,
    ST_SHOWN     = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // table write strobes
  typedef struct packed {
    logic key_we;
    logic amt_we;
  } tbl_wr_t;

endpackage : kqt_pkg
`default_nettype wire

[rtl/kqt_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_req_if: request channel of the keyed quantity table
// valid/ready handshake carrying operation, item code and quantity
// ----------------------------------------------------------------------------
interface kqt_req_if
  import kqt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  item_code;
  logic [QTY_W-1:0]  quantity;

  modport source (output valid, output func, output item_code, output quantity,
                  input ready);
  modport sink   (input valid, input func, input item_code, input quantity,
                  output ready);
endinterface : kqt_req_if
`default_nettype wire

[rtl/kqt_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_rsp_if: response channel of the keyed quantity table
// valid/ready handshake carrying status, amount and saturation flag
// ----------------------------------------------------------------------------
interface kqt_rsp_if
  import kqt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [AMT_W-1:0]    amount;
  logic                saturated;

  modport source (output valid, output status, output amount, output saturated,
                  input ready);
  modport sink   (input valid, input status, input amount, input saturated,
                  output ready);
endinterface : kqt_rsp_if
`default_nettype wire

[rtl/kqt_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_table: key and amount storage
// one write port, one registered read port, shared address per side
// ----------------------------------------------------------------------------
module kqt_table
  import kqt_pkg::*;
#(
  parameter int TABLE_ENTRIES = KQT_ENTRIES,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire tbl_wr_t          wr,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [KEY_W-1:0] wr_key,
  input  wire logic [AMT_W-1:0] wr_amt,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic      [KEY_W-1:0] rd_key,
  output logic      [AMT_W-1:0] rd_amt
);

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [AMT_W-1:0] amt_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_idx] <= wr_key;
    end
    if (wr.amt_we) begin
      amt_mem[wr_idx] <= wr_amt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_idx];
      rd_amt <= amt_mem[rd_idx];
    end
  end

endmodule : kqt_table
`default_nettype wire

[rtl/kqt_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_alu: shared add/subtract unit
// key compare during the scan, accumulate or withdraw at the update
// ----------------------------------------------------------------------------
module kqt_alu
  import kqt_pkg::*;
(
  input  wire alu_op_t          op,
  input  wire logic [AMT_W-1:0] a,
  input  wire logic [AMT_W-1:0] b,
  output logic      [AMT_W:0]   res,
  output logic                  zero
);

  // msb is the carry on add, the borrow on subtract
  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default: res = '0;
    endcase
  end

  assign zero = (res[AMT_W-1:0] == '0);

endmodule : kqt_alu
`default_nettype wire

[rtl/keyed_quantity_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_quantity_table: associative quantity table with add, take and query
// sequence: accept step, then a key scan of one entry per cycle from slot zero,
//   stopping at the first match or once every entry has been compared, then
//   the update step
// throughput: one word at a time, next request taken once the update is done;
//   a stalled response holds the update step until the old word leaves
// reset: synchronous rst empties the table (entry count to zero), no clear
//   pass, request side not ready while rst is high
// ----------------------------------------------------------------------------
module keyed_quantity_table
  import kqt_pkg::*;
#(
  parameter int TABLE_ENTRIES = KQT_ENTRIES
) (
  input wire logic clk,
  input wire logic rst,
  kqt_req_if.sink   req,
  kqt_rsp_if.source rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state;

  // control registers
  logic [CNT_W-1:0] count;      // valid entries, filled from index zero up
  logic             pend;       // a read was issued last cycle
  logic             rsp_valid;

  // request and scan payload
  func_t            func_q;
  logic [KEY_W-1:0] key_q;
  logic [QTY_W-1:0] qty_q;
  logic [CNT_W-1:0] scan_idx;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] hit_idx;
  logic             found_q;
  logic [AMT_W-1:0] cur_amt;

  // response payload
  status_t          rsp_status;
  logic [AMT_W-1:0] rsp_amount;
  logic             rsp_sat;

  // table port
  tbl_wr_t          wr;
  logic [IDX_W-1:0] wr_idx;
  logic [KEY_W-1:0] rd_key;
  logic [AMT_W-1:0] rd_amt;
  logic             rd_en;

  // shared unit
  alu_op_t          alu_op;
  logic [AMT_W-1:0] alu_a;
  logic [AMT_W-1:0] alu_b;
  logic [AMT_W:0]   alu_res;
  logic             alu_zero;

  // update decisions
  status_t          st_next;
  logic [AMT_W-1:0] amt_next;
  logic             sat_next;
  logic             new_entry;
  logic             upd_entry;

  logic issue;
  logic hit;
  logic out_free;
  logic exec_fire;

  assign req.ready     = (state == S_IDLE) && !rst;
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.amount    = rsp_amount;
  assign rsp.saturated = rsp_sat;

  // scan issues one read per cycle while entries remain
  assign issue     = (state == S_SCAN) && (scan_idx < count);
  assign rd_en     = issue;
  assign hit       = pend && alu_zero;
  assign out_free  = !rsp_valid || rsp.ready;
  assign exec_fire = (state == S_EXEC) && out_free;

  // operand select: key compare while scanning, amount update afterwards
  always_comb begin
    if (state == S_SCAN) begin
      alu_op = ALU_SUB;
      alu_a  = {{(AMT_W-KEY_W){1'b0}}, rd_key};
      alu_b  = {{(AMT_W-KEY_W){1'b0}}, key_q};
    end else begin
      alu_op = (func_q == FN_ADD) ? ALU_ADD : ALU_SUB;
      alu_a  = cur_amt;
      alu_b  = {{(AMT_W-QTY_W){1'b0}}, qty_q};
    end
  end

  kqt_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .zero (alu_zero)
  );

  // result of the update step
  always_comb begin
    st_next   = ST_MISSING;
    amt_next  = '0;
    sat_next  = 1'b0;
    new_entry = 1'b0;
    upd_entry = 1'b0;
    unique case (func_q)
      FN_ADD: begin
        if (found_q) begin
          // carry out means the sum clipped
          st_next   = ST_ADDED;
          sat_next  = alu_res[AMT_W];
          amt_next  = alu_res[AMT_W] ? {AMT_W{1'b1}} : alu_res[AMT_W-1:0];
          upd_entry = 1'b1;
        end else if (count < CNT_W'(TABLE_ENTRIES)) begin
          st_next   = ST_NEW;
          amt_next  = {{(AMT_W-QTY_W){1'b0}}, qty_q};
          new_entry = 1'b1;
        end else begin
          st_next = ST_FULL;
        end
      end
      FN_TAKE: begin
        if (found_q) begin
          // borrow means not enough stock, entry left alone
          if (alu_res[AMT_W]) begin
            st_next  = ST_SHORT;
            amt_next = cur_amt;
          end else begin
            st_next   = ST_DELIVERED;
            amt_next  = alu_res[AMT_W-1:0];
            upd_entry = 1'b1;
          end
        end
      end
      default: begin
        // query, and the spare code behaves as a query
        if (found_q) begin
          st_next  = ST_SHOWN;
          amt_next = cur_amt;
        end
      end
    endcase
  end

  assign wr.key_we = exec_fire && new_entry;
  assign wr.amt_we = exec_fire && (new_entry || upd_entry);
  assign wr_idx    = new_entry ? count[IDX_W-1:0] : hit_idx;

  kqt_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr     (wr),
    .wr_idx (wr_idx),
    .wr_key (key_q),
    .wr_amt (amt_next),
    .rd_en  (rd_en),
    .rd_idx (scan_idx[IDX_W-1:0]),
    .rd_key (rd_key),
    .rd_amt (rd_amt)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (req.valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= issue;
          // stop on the first match, or once every entry has been compared
          if (hit || (!issue && !pend)) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          pend <= 1'b0;
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
            if (new_entry) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func_q   <= func_t'(req.func);
      key_q    <= req.item_code;
      qty_q    <= req.quantity;
      scan_idx <= '0;
      found_q  <= 1'b0;
    end
    if (issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
      pend_idx <= scan_idx[IDX_W-1:0];
    end
    if (state == S_SCAN && hit) begin
      found_q <= 1'b1;
      hit_idx <= pend_idx;
      cur_amt <= rd_amt;
    end
    if (exec_fire) begin
      rsp_status <= st_next;
      rsp_amount <= amt_next;
      rsp_sat    <= sat_next;
    end
  end

  // entry count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond capacity");

  // a new entry grows the table by exactly one
  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && new_entry) |=> (count == $past(count) + CNT_W'(1)))
    else $error("new entry did not bump the count");

  // saturation is only reported on an add to an existing entry
  a_sat_added: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_sat) |-> (rsp_status == ST_ADDED))
    else $error("saturation flag on a non-add result");

  // a pending response is never overwritten by the next update
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && rsp_valid && !rsp.ready) |=> (state == S_EXEC))
    else $error("update finished while the response was stalled");

endmodule : keyed_quantity_table
`default_nettype wire

[tb/kqt_ledger_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kqt_ledger_check: stock ledger predictor and response checker
// watches both channels, keeps its own copy of the item table, works out the
// outcome of every accepted request and compares it with the response words
// ----------------------------------------------------------------------------
module kqt_ledger_check
  import kqt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  kqt_req_if          req,
  kqt_rsp_if          rsp,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned words_checked,
  output int unsigned clipped_adds,
  output logic [7:0]  statuses_seen
);

  localparam int TABLE_SLOTS = KQT_ENTRIES;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    status_t          status;
    logic [AMT_W-1:0] amount;
    logic             saturated;
  } outcome_t;

  logic [KEY_W-1:0] slot_code [TABLE_SLOTS];
  logic [AMT_W-1:0] slot_qty  [TABLE_SLOTS];
  int               slots_used;
  outcome_t         due_outcomes [$];

  task automatic report_mismatch(input string what, input logic [AMT_W-1:0] got,
                                 input logic [AMT_W-1:0] want);
    mismatches++;
    // keep the log short on a badly broken block
    if (mismatches <= PRINT_CAP)
      $display("[%0t] ledger: %s got 0x%0h want 0x%0h (response %0d)",
               $time, what, got, want, words_checked);
  endtask

  // first match from slot 0 upward; absent codes on an add append while room is left
  task automatic predict_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] code,
                                 input logic [QTY_W-1:0] qty, output outcome_t res);
    int i;
    int hit;
    logic [AMT_W:0] sum;
    hit = -1;
    for (i = 0; i < slots_used; i++)
      if (hit < 0 && slot_code[i] == code) hit = i;
    res.status    = ST_MISSING;
    res.amount    = '0;
    res.saturated = 1'b0;
    case (op)
      FN_ADD: begin
        if (hit >= 0) begin
          sum = {1'b0, slot_qty[hit]} + qty;
          if (sum[AMT_W]) begin
            slot_qty[hit] = '1;
            res.saturated = 1'b1;
          end else begin
            slot_qty[hit] = sum[AMT_W-1:0];
          end
          res.status = ST_ADDED;
          res.amount = slot_qty[hit];
        end else if (slots_used < TABLE_SLOTS) begin
          slot_code[slots_used] = code;
          slot_qty[slots_used]  = {{(AMT_W-QTY_W){1'b0}}, qty};
          slots_used++;
          res.status = ST_NEW;
          res.amount = {{(AMT_W-QTY_W){1'b0}}, qty};
        end else begin
          res.status = ST_FULL;
        end
      end
      FN_TAKE: begin
        if (hit >= 0 && slot_qty[hit] >= qty) begin
          slot_qty[hit] = slot_qty[hit] - qty;
          res.status = ST_DELIVERED;
          res.amount = slot_qty[hit];
        end else if (hit >= 0) begin
          res.status = ST_SHORT;
          res.amount = slot_qty[hit];
        end
      end
      // query, and the spare code that behaves as one
      default: begin
        if (hit >= 0) begin
          res.status = ST_SHOWN;
          res.amount = slot_qty[hit];
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      slots_used = 0;
      due_outcomes.delete();
      mismatches    = 0;
      words_checked = 0;
      clipped_adds  = 0;
      statuses_seen = '0;
      outstanding  <= 0;
    end else begin
      if (req.valid && req.ready) begin
        predict_request(req.func, req.item_code, req.quantity, want);
        if (want.saturated) clipped_adds++;
        due_outcomes.insert(due_outcomes.size(), want);
      end
      if (rsp.valid && rsp.ready) begin
        if (due_outcomes.size() == 0) begin
          report_mismatch("response with no request waiting, status", rsp.status, '0);
        end else begin
          want = due_outcomes.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.amount !== want.amount)
            report_mismatch("amount", rsp.amount, want.amount);
          if (rsp.saturated !== want.saturated)
            report_mismatch("saturated", rsp.saturated, want.saturated);
          statuses_seen[want.status] = 1'b1;
        end
        words_checked++;
      end
      outstanding <= due_outcomes.size();
    end
  end

endmodule : kqt_ledger_check
`default_nettype wire

[tb/tb_keyed_quantity_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_keyed_quantity_table: self-checking bench for the keyed quantity table
// directed requests on an empty and part-filled table, then random requests
// over a small key pool so the table fills and stays full; the ledger checker
// predicts and compares every response word
// ----------------------------------------------------------------------------
module tb_keyed_quantity_table;
  import kqt_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_BLOCKS = 9;
  localparam int BLOCK_WORDS  = 50;
  localparam int POOL_SIZE    = 24;
  localparam int SETTLE_CYCLES = 40;    // longer than the slowest full-table scan

  logic clk;
  logic rst;

  kqt_req_if req_ch ();
  kqt_rsp_if rsp_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned words_checked;
  int unsigned clipped_adds;
  logic [7:0]  statuses_seen;

  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  bit          quiet       = 1'b0;  // both sides drop their idle draws while set
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  keyed_quantity_table uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kqt_ledger_check ledger (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .clipped_adds  (clipped_adds),
    .statuses_seen (statuses_seen)
  );

  // 12 unit clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost response ends up here
  initial begin
    do @(posedge clk); while (cycle_count < CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d responses still due", cycle_count, outstanding);
    $display("keyed_quantity_table verification failed");
    $finish;
  end

  // response side: random stall before each word, none while quiet
  // ready is only lowered when a stall is drawn, so it never toggles within a step
  initial begin : drain_side
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // one request word: optional gap, then hold valid until the block takes it
  task automatic send_word(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] code,
                           input logic [QTY_W-1:0] qty);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= op;
    req_ch.item_code <= code;
    req_ch.quantity  <= qty;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    words_sent++;
  endtask

  // stop offering and hold off until every response due has come back
  task automatic wait_all_answered();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int unsigned blk;
    int unsigned k;
    int unsigned pick;
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  code;
    logic [QTY_W-1:0]  qty;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FN_ADD;
    req_ch.item_code <= '0;
    req_ch.quantity  <= '0;

    // small key pool so adds, takes and queries keep hitting stored codes;
    // all-zero and all-one codes are always in it
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) key_pool[k] = KEY_W'($urandom);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: every lookup misses, spare code acts as a query
    send_word(FN_QUERY, 16'h1234, 16'h0000);
    send_word(FN_TAKE,  16'h1234, 16'h0005);
    send_word(FN_SPARE, 16'h1234, 16'hffff);
    // first two entries, all-one code at slot 0 and all-zero code at slot 1
    send_word(FN_ADD,   16'hffff, 16'hffff);
    send_word(FN_ADD,   16'h0000, 16'h0000);
    send_word(FN_QUERY, 16'h0000, 16'hffff);
    // zero take, shortage on an empty entry, exact take down to zero
    send_word(FN_TAKE,  16'h0000, 16'h0000);
    send_word(FN_TAKE,  16'h0000, 16'h0001);
    send_word(FN_ADD,   16'h0000, 16'h8000);
    send_word(FN_TAKE,  16'h0000, 16'h8000);
    send_word(FN_SPARE, 16'hffff, 16'h0000);
    send_word(FN_TAKE,  16'hffff, 16'hffff);
    send_word(FN_QUERY, 16'hbeef, 16'h0000);
    wait_all_answered();

    // random traffic; the pool fills the table early, after that absent codes
    // hit the full case and misses scan every slot
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      quiet = (blk == 3 || blk == 7);
      if (blk == 5) wait_all_answered();
      for (k = 0; k < BLOCK_WORDS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = FN_ADD;
        else if (pick < 70) op = FN_TAKE;
        else if (pick < 90) op = FN_QUERY;
        else                op = FN_SPARE;
        if ($urandom_range(0, 9) == 0) code = KEY_W'($urandom);
        else                           code = key_pool[$urandom_range(0, POOL_SIZE-1)];
        case ($urandom_range(0, 9))
          0: begin
            qty = '0;
          end
          1: begin
            qty = '1;
          end
          2, 3: begin
            qty = QTY_W'($urandom);
          end
          default: begin
            qty = QTY_W'($urandom_range(1, 300));
          end
        endcase
        send_word(op, code, qty);
      end
    end
    quiet = 1'b0;

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d request words and %0d checked responses: empty table,",
             words_sent, words_checked);
    $display("part-filled and full table under random stalls; codes seen %b, clipped %0d, %0d cycles",
             statuses_seen, clipped_adds, cycle_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("keyed_quantity_table verification clean");
    end else begin
      $display("keyed_quantity_table verification failed");
    end
    $finish;
  end

endmodule : tb_keyed_quantity_table
`default_nettype wire
